// File: hw/rtl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scan unit.
// ----------------------------------------------------------------------------
package mbps_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 5;
	localparam int CNT_W      = 16;
	localparam int POS_W      = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MATCHES    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET    = 3'd5;

	// result kinds
	localparam logic KIND_HIT = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef struct packed {
		logic [127:0]       pattern;       // byte j in bits 8j+7:8j
		logic [15:0]        care_mask;
		logic [LEN_W-1:0]   pattern_length;
		logic [CNT_W-1:0]   max_matches;
		logic [POS_W-1:0]   base_offset;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic             kind;
		logic [POS_W-1:0] match_offset;
		logic [CNT_W-1:0] match_count;
		logic             is_last;
	} out_beat_t;

	// results caused by one byte: n of them, r0 first
	typedef struct packed {
		logic [1:0] n;
		out_beat_t  r0;
		out_beat_t  r1;
	} pair_t;

endpackage

// File: hw/rtl/mbps_stream_if.sv
// ----------------------------------------------------------------------------
// mbps_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface mbps_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: hw/rtl/masked_byte_pattern_scan_unit.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_unit
// A byte is registered in s1 and its results in the result register, from
// which they are offered; a byte with results waits in s1 for room there.
// Throughput: one byte per cycle while the result register has room or the
// byte makes none; one that both hits and ends a buffer gives two result beats.
// Reset: arst_n clears position, window fill, hit count and all valids and
// loads the register defaults; window bytes need no reset.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_unit #(
	parameter int MAX_PATTERN = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	mbps_stream_if.sink                      bytes,
	mbps_stream_if.source                    results,
	input  logic                             cfg_wr_en,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import mbps_pkg::*;

	// Data path
	//   bytes -> input register (s1) -> shift window + masked compare ->
	//   result register (up to two results) -> results
	// The compare runs on the window as it stands after the new byte shifts
	// in, so state update and result building happen in the same cycle the
	// byte leaves s1. A byte that makes no result leaves s1 even while the
	// result register is full; a byte that makes results waits for room.

	cfg_t  cfg;
	logic  take_ok;
	logic  push;
	pair_t pair;

	// hold the register file; write it only while the scan is idle
	mbps_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// advance the window and scan state, build the results of each byte
	mbps_scan #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (bytes.valid),
		.in_ready (bytes.ready),
		.in_beat  (bytes.payload),
		.take_ok  (take_ok),
		.push     (push),
		.pair     (pair)
	);

	// drain the held results one beat at a time, hit before end
	mbps_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pair      (pair),
		.take_ok   (take_ok),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.out_beat  (results.payload)
	);

endmodule

// File: hw/rtl/mbps_cfg.sv
// ----------------------------------------------------------------------------
// mbps_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
module mbps_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]   index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0]  data,
	output mbps_pkg::cfg_t                   cfg
);
	import mbps_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern        <= '0;
			cfg_q.care_mask      <= 16'hFFFF;
			cfg_q.pattern_length <= LEN_W'(1);
			cfg_q.max_matches    <= 16'hFFFF;
			cfg_q.base_offset    <= '0;
		end else if (wr_en) begin
			case (index)
				REG_PATTERN_LOW:    cfg_q.pattern[63:0]   <= data;
				REG_PATTERN_HIGH:   cfg_q.pattern[127:64] <= data;
				REG_CARE_MASK:      cfg_q.care_mask       <= data[15:0];
				REG_PATTERN_LENGTH: cfg_q.pattern_length  <= data[LEN_W-1:0];
				REG_MAX_MATCHES:    cfg_q.max_matches     <= data[CNT_W-1:0];
				REG_BASE_OFFSET:    cfg_q.base_offset     <= data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/mbps_scan.sv
// ----------------------------------------------------------------------------
// mbps_scan
// Input register, byte window, masked compare and per-buffer scan state.
// ----------------------------------------------------------------------------
module mbps_scan #(
	parameter int MAX_PATTERN = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mbps_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  mbps_pkg::in_beat_t in_beat,
	input  logic               take_ok,
	output logic               push,
	output mbps_pkg::pair_t    pair
);
	import mbps_pkg::*;

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int WIN_W  = 8 * MAX_PATTERN;
	localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_PATTERN);
	localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(MAX_PATTERN);

	logic              valid_s1;
	in_beat_t          beat_s1;
	logic [7:0]        win_q [MAX_PATTERN];
	logic [FILL_W-1:0] fill_q;
	logic [POS_W-1:0]  pos_q;
	logic [CNT_W-1:0]  hits_q;

	logic [WIN_W-1:0]       win_next;
	logic [WIN_W-1:0]       aligned;
	logic [LEN_W-1:0]       len_c;
	logic [LEN_W-1:0]       shamt;
	logic [FILL_W-1:0]      fill_next;
	logic [MAX_PATTERN-1:0] byte_ok;
	logic [CNT_W-1:0]       hits_inc;
	logic [POS_W-1:0]       start_pos;
	out_beat_t              r_hit;
	out_beat_t              r_end;
	logic                   hit;
	logic                   advance;

	// shifted window, newest byte on top
	always_comb begin
		for (int k = 0; k < MAX_PATTERN - 1; k++) begin
			win_next[8*k +: 8] = win_q[k+1];
		end
		win_next[8*(MAX_PATTERN-1) +: 8] = beat_s1.data_byte;
	end

	assign len_c   = (cfg.pattern_length > MAX_LEN) ? MAX_LEN : cfg.pattern_length;
	assign shamt   = MAX_LEN - len_c;
	assign aligned = win_next >> {shamt, 3'b000};

	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			byte_ok[j] = (LEN_W'(j) >= len_c) || !cfg.care_mask[j]
				|| (aligned[8*j +: 8] == cfg.pattern[8*j +: 8]);
		end
	end

	assign fill_next = (fill_q < MAX_FILL) ? fill_q + 1'b1 : fill_q;
	assign hit = (len_c != '0) && (LEN_W'(fill_next) >= len_c)
		&& (hits_q < cfg.max_matches) && (&byte_ok);

	assign hits_inc  = hits_q + 1'b1;
	assign start_pos = pos_q + POS_W'(1) - POS_W'(len_c);

	always_comb begin
		r_hit.kind         = KIND_HIT;
		r_hit.match_offset = cfg.base_offset + start_pos;
		r_hit.match_count  = hits_inc;
		r_hit.is_last      = !beat_s1.last_byte;
		r_end.kind         = KIND_END;
		r_end.match_offset = '0;
		r_end.match_count  = hit ? hits_inc : hits_q;
		r_end.is_last      = 1'b1;
		if (hit) begin
			pair.r0 = r_hit;
			pair.r1 = r_end;
			pair.n  = beat_s1.last_byte ? 2'd2 : 2'd1;
		end else begin
			pair.r0 = r_end;
			pair.r1 = r_end;
			pair.n  = beat_s1.last_byte ? 2'd1 : 2'd0;
		end
	end

	// a byte with no result moves on even while the result side is full
	assign push     = valid_s1 && (pair.n != 2'd0);
	assign advance  = valid_s1 && ((pair.n == 2'd0) || take_ok);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			beat_s1 <= in_beat;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < MAX_PATTERN; k++) begin
				win_q[k] <= win_next[8*k +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pos_q  <= '0;
			hits_q <= '0;
		end else if (advance) begin
			if (beat_s1.last_byte) begin
				fill_q <= '0;
				pos_q  <= '0;
				hits_q <= '0;
			end else begin
				fill_q <= hit ? '0 : fill_next;
				pos_q  <= pos_q + 1'b1;
				hits_q <= hit ? hits_inc : hits_q;
			end
		end
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && beat_s1.last_byte |=> fill_q == '0 && pos_q == '0 && hits_q == '0)
		else $error("scan state not cleared after end of buffer");

	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && hit && !beat_s1.last_byte |=> hits_q == $past(hits_q) + 1'b1
			&& fill_q == '0)
		else $error("hit did not bump count and restart fill");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(beat_s1))
		else $error("stalled byte lost from input register");

endmodule

// File: hw/rtl/mbps_out.sv
// ----------------------------------------------------------------------------
// mbps_out
// Result register: holds up to two results of one byte, sends one per beat.
// ----------------------------------------------------------------------------
module mbps_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mbps_pkg::pair_t     pair,
	output logic                take_ok,
	output logic                out_valid,
	input  logic                out_ready,
	output mbps_pkg::out_beat_t out_beat
);
	import mbps_pkg::*;

	logic [1:0] cnt_q;
	out_beat_t  slot0_q;
	out_beat_t  slot1_q;
	logic       load;
	logic       drain;

	assign take_ok   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign load      = push && take_ok;
	assign out_valid = (cnt_q != 2'd0);
	assign drain     = out_valid && out_ready;
	assign out_beat  = slot0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= pair.n;
		end else if (drain) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= pair.r0;
			slot1_q <= pair.r1;
		end else if (drain) begin
			slot0_q <= slot1_q;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result register count out of range");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_beat.kind == KIND_END |-> out_beat.is_last)
		else $error("end result not marked last");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> slot0_q.kind == KIND_HIT && !slot0_q.is_last
			&& slot1_q.kind == KIND_END)
		else $error("two results held but not hit then end");

endmodule

// File: tb/sv/tb_masked_byte_pattern_scan_unit.sv
// ----------------------------------------------------------------------------
// tb_masked_byte_pattern_scan_unit
// Self-checking bench for the masked byte pattern scan unit. A behavioral
// tracker mirrors the window, fill, position and hit count, predicts the hit
// and end-of-buffer beats for every accepted byte, and compares them in order
// with what the unit returns. Directed buffers cover the register extremes,
// then random buffers carry planted signatures under changing settings and
// random back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_masked_byte_pattern_scan_unit;
	import mbps_pkg::*;

	localparam int MAX_PAT      = 16;
	localparam int LAT_SLACK    = 6;     // cycles for a byte in flight to clear
	localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either channel
	localparam int PHASE_BYTES  = 540;   // random bytes per idling phase

	// ------------------------------------------------------------------------
	// Behavioral tracker: register copy, scan state and the beats still owed
	// ------------------------------------------------------------------------
	class signature_tracker;
		logic [127:0] pattern;
		logic [15:0]  care;
		logic [4:0]   pat_len;
		logic [15:0]  max_hits;
		logic [31:0]  base;

		logic [7:0]   window [MAX_PAT];
		logic [31:0]  pos;
		int unsigned  fill;
		logic [15:0]  hit_cnt;

		out_beat_t    reports_due [$];
		int unsigned  failures;
		int unsigned  bytes_seen;
		int unsigned  buffers_closed;
		int unsigned  hits_checked;
		int unsigned  ends_checked;
		int unsigned  reg_writes;

		function new();
			pattern  = '0;
			care     = 16'hFFFF;
			pat_len  = 5'd1;
			max_hits = 16'hFFFF;
			base     = '0;
			foreach (window[k]) window[k] = 8'h00;
			pos      = '0;
			fill     = 0;
			hit_cnt  = '0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
			case (idx)
				REG_PATTERN_LOW:    pattern[63:0]   = val;
				REG_PATTERN_HIGH:   pattern[127:64] = val;
				REG_CARE_MASK:      care            = val[15:0];
				REG_PATTERN_LENGTH: pat_len         = val[4:0];
				REG_MAX_MATCHES:    max_hits        = val[15:0];
				REG_BASE_OFFSET:    base            = val[31:0];
				default: ;
			endcase
			reg_writes++;
		endfunction

		// shift the byte in, compare the newest bytes, queue hit and end beats
		function void take_byte(in_beat_t beat);
			int unsigned span;
			int unsigned k;
			logic [31:0] cur;
			logic        matched;
			out_beat_t   rep;
			span = (pat_len > MAX_PAT) ? MAX_PAT : pat_len;
			for (k = 0; k + 1 < MAX_PAT; k++)
				window[k] = window[k + 1];
			window[MAX_PAT - 1] = beat.data_byte;
			if (fill < MAX_PAT)
				fill++;
			cur = pos;
			pos = cur + 1;
			bytes_seen++;
			matched = (span != 0) && (fill >= span) && (hit_cnt < max_hits);
			for (k = 0; k < span; k++)
				if (matched && care[k] && window[MAX_PAT - span + k] != pattern[8*k +: 8])
					matched = 1'b0;
			if (matched) begin
				hit_cnt          = hit_cnt + 16'd1;
				fill             = 0;
				rep.kind         = KIND_HIT;
				rep.match_offset = base + cur + 1 - span;
				rep.match_count  = hit_cnt;
				rep.is_last      = !beat.last_byte;
				reports_due.push_back(rep);
			end
			if (beat.last_byte) begin
				rep.kind         = KIND_END;
				rep.match_offset = '0;
				rep.match_count  = hit_cnt;
				rep.is_last      = 1'b1;
				reports_due.push_back(rep);
				pos     = '0;
				fill    = 0;
				hit_cnt = '0;
				buffers_closed++;
			end
		endfunction

		function void check_report(out_beat_t got);
			out_beat_t want;
			if (reports_due.size() == 0) begin
				$error("result beat with none due: kind %0d offset %0h count %0d",
					got.kind, got.match_offset, got.match_count);
				failures++;
				return;
			end
			want = reports_due.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				failures++;
			end
			if (got.match_offset !== want.match_offset) begin
				$error("match_offset: expected %0h, got %0h", want.match_offset,
					got.match_offset);
				failures++;
			end
			if (got.match_count !== want.match_count) begin
				$error("match_count: expected %0d, got %0d", want.match_count,
					got.match_count);
				failures++;
			end
			if (got.is_last !== want.is_last) begin
				$error("is_last: expected %0d, got %0d", want.is_last, got.is_last);
				failures++;
			end
			if (want.kind == KIND_HIT)
				hits_checked++;
			else
				ends_checked++;
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels and the unit
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mbps_stream_if #(.payload_t(in_beat_t))  byte_ch ();
	mbps_stream_if #(.payload_t(out_beat_t)) result_ch ();

	signature_tracker tracker;

	int unsigned src_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned items_sent;
	int unsigned quiet_cycles;

	always #4 clk = ~clk;

	masked_byte_pattern_scan_unit #(.MAX_PATTERN(MAX_PAT)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (byte_ch),
		.results   (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Receiver, monitors and watchdog. Everything here samples the values
	// that held just before the edge, so ordering within the step is moot.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		// stall the result channel at random in the current phase
		result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		if (arst_n) begin
			// note the byte first: a result never leaves in the cycle its byte enters
			if (byte_ch.valid && byte_ch.ready)
				tracker.take_byte(byte_ch.payload);
			if (result_ch.valid && result_ch.ready)
				tracker.check_report(result_ch.payload);
			if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks
	// ------------------------------------------------------------------------

	// Offer one byte, after a random gap, and hold it until the unit takes it.
	// Valid is only lowered when a gap is taken, so it never gets two updates
	// in the same step.
	task automatic send_byte(input logic [7:0] data, input logic closes);
		if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		byte_ch.valid   <= 1'b1;
		byte_ch.payload <= {data, closes};
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Drop valid and wait until every owed beat has come back, then give a
	// byte that caused no result time to leave the pipeline.
	task automatic settle();
		byte_ch.valid <= 1'b0;
		@(posedge clk);
		while (tracker.reports_due.size() != 0) @(posedge clk);
		repeat (LAT_SLACK) @(posedge clk);
	endtask

	// One register write per edge; the caller drops the write enable after
	// the last one of a batch.
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		tracker.write_reg(idx, val);
		@(posedge clk);
	endtask

	task automatic load_config(input logic [127:0] pat, input logic [15:0] mask,
			input logic [4:0] len, input logic [15:0] limit, input logic [31:0] base);
		settle();
		set_reg(REG_PATTERN_LOW,    pat[63:0]);
		set_reg(REG_PATTERN_HIGH,   pat[127:64]);
		set_reg(REG_CARE_MASK,      {48'd0, mask});
		set_reg(REG_PATTERN_LENGTH, {59'd0, len});
		set_reg(REG_MAX_MATCHES,    {48'd0, limit});
		set_reg(REG_BASE_OFFSET,    {32'd0, base});
		cfg_wr_en <= 1'b0;
	endtask

	// Draw a setting, leaning toward the edges of each register's range.
	task automatic random_config();
		logic [127:0] pat;
		logic [15:0]  mask;
		logic [4:0]   len;
		logic [15:0]  limit;
		logic [31:0]  base;
		pat = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(4))
			0:       mask = 16'h0000;
			1:       mask = 16'hFFFF;
			default: mask = 16'($urandom_range(16'hFFFF));
		endcase
		case ($urandom_range(19))
			0:       len = 5'd0;
			1:       len = 5'd16;
			2:       len = 5'($urandom_range(17, 31));
			3:       len = 5'd1;
			default: len = 5'($urandom_range(1, 16));
		endcase
		case ($urandom_range(9))
			0:       limit = 16'd0;
			1, 2:    limit = 16'($urandom_range(1, 3));
			3:       limit = 16'($urandom_range(1, 16'hFFFF));
			default: limit = 16'hFFFF;
		endcase
		case ($urandom_range(5))
			0:       base = 32'h0000_0000;
			1:       base = 32'hFFFF_FFFF;
			2:       base = 32'hFFFF_FFF0 + $urandom_range(15);
			default: base = $urandom;
		endcase
		load_config(pat, mask, len, limit, base);
	endtask

	// One buffer: filler bytes with signature copies planted at random, the
	// wildcard positions of each copy filled with random bytes. Now and then
	// pause mid-buffer and change only the length.
	task automatic send_buffer(input int unsigned nbytes, input int unsigned plant_pct);
		int unsigned i;
		int unsigned j;
		int unsigned span;
		int unsigned pick;
		logic [7:0]  data;
		i = 0;
		while (i < nbytes) begin
			span = (tracker.pat_len > MAX_PAT) ? MAX_PAT : tracker.pat_len;
			if (span != 0 && i + span <= nbytes && $urandom_range(99) < plant_pct) begin
				for (j = 0; j < span; j++) begin
					data = tracker.care[j] ? tracker.pattern[8*j +: 8]
						: 8'($urandom_range(255));
					send_byte(data, i + 1 == nbytes);
					i++;
				end
			end else begin
				// filler drawn partly from the signature bytes to provoke near misses
				pick = $urandom_range(15);
				data = ($urandom_range(3) == 0) ? tracker.pattern[8*pick +: 8]
					: 8'($urandom_range(255));
				send_byte(data, i + 1 == nbytes);
				i++;
			end
			if (i < nbytes && $urandom_range(199) == 0) begin
				settle();
				set_reg(REG_PATTERN_LENGTH, 64'($urandom_range(0, 20)));
				cfg_wr_en <= 1'b0;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned ph;
		int unsigned k;
		int unsigned target;
		int unsigned nbuf;

		tracker           = new();
		arst_n            = 1'b0;
		cfg_wr_en         = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.payload   = '0;
		items_sent        = 0;
		quiet_cycles      = 0;
		src_idle_pct      = 36;
		rx_idle_pct       = 45;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: a one-byte zero signature, so every zero byte hits.
		// The closing byte gives a hit and the end beat together.
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);

		// Three-byte signature with its middle byte free, two hits allowed and
		// a base just below the wrap: the second hit's offset wraps to 1, the
		// third copy is past the limit. Then a buffer shorter than the pattern.
		load_config(128'h00_10_78, 16'h0005, 5'd3, 16'd2, 32'hFFFF_FFFE);
		send_byte(8'h78, 1'b0);
		send_byte(8'h55, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(8'h10, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h78, 1'b1);

		// Length zero and a match limit of zero both disable hits.
		load_config('0, 16'hFFFF, 5'd0, 16'hFFFF, 32'h0);
		send_byte(8'h00, 1'b1);
		load_config('0, 16'hFFFF, 5'd1, 16'd0, 32'h0);
		send_byte(8'h00, 1'b1);

		// Length above the maximum acts as the maximum; with no byte cared
		// for, the sixteenth byte hits and closes the buffer.
		load_config({$urandom, $urandom, $urandom, $urandom}, 16'h0000, 5'd31,
			16'hFFFF, 32'h0000_1000);
		for (k = 0; k < MAX_PAT; k++)
			send_byte(8'($urandom_range(255)), k == MAX_PAT - 1);

		// Random part: three idling phases, receiver-heavy, sender-heavy, none.
		// Each setting change drains the unit first, which also holds the
		// sender off until every owed beat is back.
		for (ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 45 : 0;
			rx_idle_pct  = (ph == 0) ? 45 : (ph == 1) ? 36 : 0;
			target = items_sent + PHASE_BYTES;
			while (items_sent < target) begin
				random_config();
				nbuf = $urandom_range(2, 6);
				for (k = 0; k < nbuf; k++) begin
					if ($urandom_range(4) == 0)
						send_buffer($urandom_range(1, 12), 0);
					else if ($urandom_range(9) == 0)
						send_buffer($urandom_range(24, 60), 40);
					else
						send_buffer($urandom_range(1, 24), 45);
				end
			end
		end

		settle();

		$display("Scanned %0d bytes in %0d buffers over %0d register writes",
			tracker.bytes_seen, tracker.buffers_closed, tracker.reg_writes);
		$display("Compared %0d hit beats and %0d end-of-buffer beats",
			tracker.hits_checked, tracker.ends_checked);
		if (tracker.failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/mbps_pkg.sv
hw/rtl/mbps_stream_if.sv
hw/rtl/mbps_cfg.sv
hw/rtl/mbps_scan.sv
hw/rtl/mbps_out.sv
hw/rtl/masked_byte_pattern_scan_unit.sv
tb/sv/tb_masked_byte_pattern_scan_unit.sv
